[src/msrg_pkg.sv]
// Package for the multi-stop row gradient: widths, stop tables, reciprocal constants.
// No dependencies; imported by multi_stop_row_gradient.
package msrg_pkg;

	localparam int ROW_W   = 12;
	localparam int HGT_W   = 13;
	localparam int POS_W   = 10;
	localparam int NUM_W   = 22;
	localparam int CH_W    = 8;
	localparam int CFG_IDX_W = 8;

	// Tallest bar that the position math covers; taller heights saturate.
	localparam int MAX_ROWS  = 4096;
	localparam int POS_SCALE = 1000;

	// Quotient bits of row * 1000 / (height - 1); the quotient never exceeds 1000.
	localparam int DIV_STEPS = POS_W;

	localparam logic [CFG_IDX_W-1:0] CFG_TABLE_SELECT = CFG_IDX_W'(0);
	localparam logic [CFG_IDX_W-1:0] CFG_BAR_HEIGHT   = CFG_IDX_W'(1);

	localparam int BLUE_N = 10;
	localparam int GREY_N = 6;
	localparam int SEG_W  = 4;

	typedef struct packed {
		logic [POS_W-1:0]         pos;
		logic [2:0][CH_W-1:0]     rgb;   // [2] red, [1] green, [0] blue
	} stop_t;

	localparam stop_t BLUE_STOPS [BLUE_N] = '{
		'{10'd0,    '{8'd49, 8'd104, 8'd213}},
		'{10'd35,   '{8'd56, 8'd136, 8'd233}},
		'{10'd80,   '{8'd73, 8'd147, 8'd230}},
		'{10'd120,  '{8'd48, 8'd123, 8'd229}},
		'{10'd160,  '{8'd38, 8'd106, 8'd236}},
		'{10'd200,  '{8'd48, 8'd103, 8'd221}},
		'{10'd850,  '{8'd48, 8'd105, 8'd224}},
		'{10'd900,  '{8'd33, 8'd92,  8'd228}},
		'{10'd950,  '{8'd30, 8'd80,  8'd196}},
		'{10'd1000, '{8'd25, 8'd65,  8'd165}}
	};

	localparam stop_t GREY_STOPS [GREY_N] = '{
		'{10'd0,    '{8'd108, 8'd116, 8'd126}},
		'{10'd25,   '{8'd76,  8'd84,  8'd94}},
		'{10'd60,   '{8'd46,  8'd52,  8'd60}},
		'{10'd200,  '{8'd32,  8'd36,  8'd42}},
		'{10'd850,  '{8'd26,  8'd29,  8'd34}},
		'{10'd1000, '{8'd16,  8'd18,  8'd21}}
	};

	// Segment weight: w = off * 255 / span, done as (off * 255 * RCP) >> RCP_SHIFT
	// with RCP = ceil(2^RCP_SHIFT / span). Exact because 2^28 > 165750 * 650.
	localparam int RCP_W     = 24;
	localparam int RCP_SHIFT = 28;
	localparam int XW        = 18;

	localparam logic [RCP_W-1:0] RCP_25  = RCP_W'(((1 << RCP_SHIFT) + 24) / 25);
	localparam logic [RCP_W-1:0] RCP_35  = RCP_W'(((1 << RCP_SHIFT) + 34) / 35);
	localparam logic [RCP_W-1:0] RCP_40  = RCP_W'(((1 << RCP_SHIFT) + 39) / 40);
	localparam logic [RCP_W-1:0] RCP_45  = RCP_W'(((1 << RCP_SHIFT) + 44) / 45);
	localparam logic [RCP_W-1:0] RCP_50  = RCP_W'(((1 << RCP_SHIFT) + 49) / 50);
	localparam logic [RCP_W-1:0] RCP_140 = RCP_W'(((1 << RCP_SHIFT) + 139) / 140);
	localparam logic [RCP_W-1:0] RCP_150 = RCP_W'(((1 << RCP_SHIFT) + 149) / 150);
	localparam logic [RCP_W-1:0] RCP_650 = RCP_W'(((1 << RCP_SHIFT) + 649) / 650);

	localparam logic [RCP_W-1:0] BLUE_RCP [BLUE_N-1] = '{
		RCP_35, RCP_45, RCP_40, RCP_40, RCP_40, RCP_650, RCP_50, RCP_50, RCP_50
	};
	localparam logic [RCP_W-1:0] GREY_RCP [GREY_N-1] = '{
		RCP_25, RCP_35, RCP_140, RCP_650, RCP_150
	};

	// Channel step: q = p / 255 as (p * DIV255_M) >> DIV255_SHIFT, exact for p <= 65025.
	localparam int DM_W          = 17;
	localparam int DIV255_SHIFT  = 24;
	localparam logic [DM_W-1:0] DIV255_M = DM_W'(((1 << DIV255_SHIFT) + 254) / 255);

	function automatic stop_t get_stop(input logic tsel, input logic [SEG_W-1:0] idx);
		stop_t s;
		if (tsel) begin
			s = (idx < SEG_W'(GREY_N)) ? GREY_STOPS[3'(idx)] : GREY_STOPS[GREY_N-1];
		end else begin
			s = (idx < SEG_W'(BLUE_N)) ? BLUE_STOPS[idx] : BLUE_STOPS[BLUE_N-1];
		end
		return s;
	endfunction

	function automatic logic [RCP_W-1:0] get_rcp(input logic tsel, input logic [SEG_W-1:0] idx);
		logic [RCP_W-1:0] m;
		if (tsel) begin
			m = (idx < SEG_W'(GREY_N-1)) ? GREY_RCP[3'(idx)] : GREY_RCP[GREY_N-2];
		end else begin
			m = (idx < SEG_W'(BLUE_N-1)) ? BLUE_RCP[idx] : BLUE_RCP[BLUE_N-2];
		end
		return m;
	endfunction

endpackage

[src/multi_stop_row_gradient.sv]
// Top level of the multi-stop row gradient: a 17-stage pipeline from row index to RGB.
// Depends on msrg_pkg (widths, stop tables, reciprocal constants).
//
// Usage: each input item on in_valid/in_ready carries one row_index; each output item on
// out_valid/out_ready carries the red, green and blue of that row, in input order.
// The configuration port (cfg_wr_en, cfg_index, cfg_wdata) writes table_select
// (index 0) and bar_height (index 1); it must only be written while no item is in flight.
// Other indices are ignored.
//
// An accepted item moves from the stage 1 register through each stage register in turn to
// the stage 17 output register, where out_valid shows it. Throughput is one item per cycle
// unless every stage is full and the receiver stalls; each divider stage is one 23-bit
// compare and subtract, and the divider that forms row * 1000 / (height - 1) is unrolled
// one quotient bit per stage, so it takes a new item every cycle unless the pipeline stalls.
//
// Reset clears every valid bit and loads table_select = 0 and bar_height = 30.
// When the receiver stalls, the result waits in the output register and the stages
// behind it keep filling: in_ready drops only once every stage holds an item.
module multi_stop_row_gradient
	import msrg_pkg::*;
(
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  cfg_wr_en,
	input  logic [CFG_IDX_W-1:0]  cfg_index,
	input  logic [HGT_W-1:0]      cfg_wdata,
	input  logic                  in_valid,
	output logic                  in_ready,
	input  logic [ROW_W-1:0]      row_index,
	output logic                  out_valid,
	input  logic                  out_ready,
	output logic [CH_W-1:0]       red,
	output logic [CH_W-1:0]       green,
	output logic [CH_W-1:0]       blue
);

	// Stage map: 1 clamp row, 2 scale by 1000, 3..12 divider, 13 segment search,
	// 14 weight operands, 15 weight, 16 channel products, 17 output register.
	localparam int S_DIV0 = 3;
	localparam int S_SEG  = S_DIV0 + DIV_STEPS;
	localparam int S_WOP  = S_SEG + 1;
	localparam int S_W    = S_WOP + 1;
	localparam int S_PRD  = S_W + 1;
	localparam int NS     = S_PRD + 1;

	// ---------------- configuration ----------------
	logic              tsel_q;
	logic [HGT_W-1:0]  rowmax_q;    // effective height - 1
	logic [HGT_W-1:0]  divisor_q;   // same, but never zero

	logic [HGT_W-1:0]  h_nz;
	logic [HGT_W-1:0]  h_cap;
	logic [HGT_W-1:0]  h_last;

	always_comb begin
		h_nz   = (cfg_wdata == '0) ? HGT_W'(1) : cfg_wdata;
		h_cap  = (32'(h_nz) > MAX_ROWS) ? HGT_W'(MAX_ROWS) : h_nz;
		h_last = h_cap - HGT_W'(1);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			tsel_q    <= 1'b0;
			rowmax_q  <= HGT_W'(29);
			divisor_q <= HGT_W'(29);
		end else if (cfg_wr_en) begin
			case (cfg_index)
				CFG_TABLE_SELECT: tsel_q <= cfg_wdata[0];
				CFG_BAR_HEIGHT: begin
					rowmax_q  <= h_last;
					// A one-row bar divides zero by one, which gives position 0.
					divisor_q <= (h_last == '0) ? HGT_W'(1) : h_last;
				end
				default: ;
			endcase
		end
	end

	// ---------------- flow control ----------------
	// A stage loads unless it and every stage after it are full and the output is stalled.
	logic [NS:1] vld_q;
	logic [NS:1] en;

	for (genvar i = 1; i <= NS; i++) begin : g_flow
		assign en[i] = out_ready | ~(&vld_q[NS:i]);
		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				vld_q[i] <= 1'b0;
			end else if (en[i]) begin
				if (i == 1) begin
					vld_q[i] <= in_valid;
				end else begin
					vld_q[i] <= vld_q[(i > 1) ? i - 1 : 1];
				end
			end
		end
	end

	assign in_ready  = en[1];
	assign out_valid = vld_q[NS];

	// ---------------- stage 1: clamp row ----------------
	logic [ROW_W-1:0] row_s1;

	always_ff @(posedge clk) begin
		if (en[1]) begin
			row_s1 <= ({1'b0, row_index} > rowmax_q) ? rowmax_q[ROW_W-1:0] : row_index;
		end
	end

	// ---------------- stage 2: numerator ----------------
	logic [NUM_W-1:0] num_s2;

	always_ff @(posedge clk) begin
		if (en[2]) begin
			num_s2 <= NUM_W'(row_s1) * NUM_W'(POS_SCALE);
		end
	end

	// ---------------- stages 3..12: restoring divider ----------------
	logic [NUM_W-1:0] div_rem_s [DIV_STEPS];
	logic [POS_W-1:0] div_quo_s [DIV_STEPS];

	for (genvar j = 0; j < DIV_STEPS; j++) begin : g_div
		logic [NUM_W-1:0] rem_in;
		logic [POS_W-1:0] quo_in;
		logic [NUM_W:0]   trial;

		if (j == 0) begin : g_first
			assign rem_in = num_s2;
			assign quo_in = '0;
		end else begin : g_next
			assign rem_in = div_rem_s[j-1];
			assign quo_in = div_quo_s[j-1];
		end

		assign trial = {1'b0, rem_in} - ((NUM_W+1)'(divisor_q) << (DIV_STEPS - 1 - j));

		always_ff @(posedge clk) begin
			if (en[S_DIV0 + j]) begin
				div_rem_s[j] <= trial[NUM_W] ? rem_in : trial[NUM_W-1:0];
				div_quo_s[j] <= quo_in | (POS_W'(!trial[NUM_W]) << (DIV_STEPS - 1 - j));
			end
		end
	end

	logic [POS_W-1:0] pos;
	assign pos = div_quo_s[DIV_STEPS-1];

	// ---------------- stage 13: bracketing stops ----------------
	// The lower stop index is the number of stops past the first that lie below pos.
	logic [SEG_W-1:0] seg_blue;
	logic [SEG_W-1:0] seg_grey;
	logic [SEG_W-1:0] seg;
	stop_t            lo_stop;
	logic [SEG_W-1:0] seg_s13;
	logic [POS_W-1:0] off_s13;

	always_comb begin
		seg_blue = '0;
		seg_grey = '0;
		for (int k = 1; k < BLUE_N; k++) begin
			seg_blue = seg_blue + SEG_W'(BLUE_STOPS[k].pos < pos);
		end
		for (int k = 1; k < GREY_N; k++) begin
			seg_grey = seg_grey + SEG_W'(GREY_STOPS[k].pos < pos);
		end
		seg     = tsel_q ? seg_grey : seg_blue;
		lo_stop = get_stop(tsel_q, seg);
	end

	always_ff @(posedge clk) begin
		if (en[S_SEG]) begin
			seg_s13 <= seg;
			off_s13 <= pos - lo_stop.pos;
		end
	end

	// ---------------- stage 14: weight operands ----------------
	logic [SEG_W-1:0] seg_s14;
	logic [XW-1:0]    x_s14;
	logic [RCP_W-1:0] rcp_s14;

	always_ff @(posedge clk) begin
		if (en[S_WOP]) begin
			seg_s14 <= seg_s13;
			x_s14   <= (XW'(off_s13) << 8) - XW'(off_s13);
			rcp_s14 <= get_rcp(tsel_q, seg_s13);
		end
	end

	// ---------------- stage 15: weight ----------------
	logic [XW+RCP_W-1:0] w_prod;
	logic [SEG_W-1:0]    seg_s15;
	logic [CH_W-1:0]     w_s15;

	assign w_prod = (XW+RCP_W)'(x_s14) * (XW+RCP_W)'(rcp_s14);

	always_ff @(posedge clk) begin
		if (en[S_W]) begin
			seg_s15 <= seg_s14;
			w_s15   <= w_prod[RCP_SHIFT +: CH_W];
		end
	end

	// ---------------- stage 16: channel products ----------------
	stop_t             lo_c;
	stop_t             hi_c;
	logic [2*CH_W-1:0] prod_s16 [3];
	logic              neg_s16  [3];
	logic [CH_W-1:0]   lo_s16   [3];

	always_comb begin
		lo_c = get_stop(tsel_q, seg_s15);
		hi_c = get_stop(tsel_q, seg_s15 + SEG_W'(1));
	end

	for (genvar c = 0; c < 3; c++) begin : g_prod
		logic [CH_W:0]   diff;
		logic [CH_W-1:0] mag;

		assign diff = {1'b0, hi_c.rgb[c]} - {1'b0, lo_c.rgb[c]};
		assign mag  = diff[CH_W] ? CH_W'(-diff) : diff[CH_W-1:0];

		always_ff @(posedge clk) begin
			if (en[S_PRD]) begin
				prod_s16[c] <= (2*CH_W)'(mag) * (2*CH_W)'(w_s15);
				neg_s16[c]  <= diff[CH_W];
				lo_s16[c]   <= lo_c.rgb[c];
			end
		end
	end

	// ---------------- stage 17: output register ----------------
	// The magnitude is divided by 255 before the sign goes back on, so the step
	// truncates toward zero; the sum always lies between the two stop values.
	logic [CH_W-1:0] rgb_s17 [3];

	for (genvar c = 0; c < 3; c++) begin : g_out
		logic [2*CH_W+DM_W-1:0] q_prod;
		logic [CH_W-1:0]        q;

		assign q_prod = (2*CH_W+DM_W)'(prod_s16[c]) * (2*CH_W+DM_W)'(DIV255_M);
		assign q      = q_prod[DIV255_SHIFT +: CH_W];

		always_ff @(posedge clk) begin
			if (en[NS]) begin
				rgb_s17[c] <= neg_s16[c] ? (lo_s16[c] - q) : (lo_s16[c] + q);
			end
		end
	end

	assign red   = rgb_s17[2];
	assign green = rgb_s17[1];
	assign blue  = rgb_s17[0];

	// ---------------- assertions ----------------
	a_ready_when_out_empty: assert property (@(posedge clk) disable iff (!arst_n)
		!out_valid |-> in_ready)
		else $error("input stalled while the output register is empty");

	a_full_stall: assert property (@(posedge clk) disable iff (!arst_n)
		((&vld_q) && !out_ready) |-> !in_ready)
		else $error("input accepted while every stage is full and stalled");

	a_pos_range: assert property (@(posedge clk) disable iff (!arst_n)
		vld_q[S_SEG-1] |-> (pos <= POS_W'(POS_SCALE)))
		else $error("divider produced a position above full scale");

	a_seg_range: assert property (@(posedge clk) disable iff (!arst_n)
		vld_q[S_SEG] |-> (seg_s13 < (tsel_q ? SEG_W'(GREY_N-1) : SEG_W'(BLUE_N-1))))
		else $error("segment index past the last pair of stops");

endmodule
